// ===== sv/fxdec_pkg.sv =====
package fxdec_pkg;

   // Default build parameters
   localparam int DEF_MAX_WIDTH  = 32;
   localparam int DEF_FRAC_BITS  = 24;
   localparam int DEF_VALUE_BITS = 64;

   // Field widths fixed by the interface
   localparam int VALUE_W = 64;
   localparam int CHAR_W  = 8;
   localparam int CFG_W   = 6;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // Register indexes (paddr bit 2 selects the register)
   localparam logic REG_FIELD_WIDTH  = 1'b0;
   localparam logic REG_SCALE_DIGITS = 1'b1;

   // Register reset values
   localparam logic [CFG_W-1:0] FIELD_WIDTH_RST  = 6'd10;
   localparam logic [CFG_W-1:0] SCALE_DIGITS_RST = 6'd2;

   // Characters
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   // BCD digit constants
   localparam logic [3:0] BCD_NINE = 4'd9;
   localparam logic [3:0] BCD_FIVE = 4'd5;
   localparam logic [3:0] BCD_ADJ  = 4'd3;

endpackage

// ===== sv/fixed_to_decimal_ascii_field.sv =====
// Converts one signed fixed-point word (VALUE_BITS bits, FRAC_BITS fractional bits, taken
// from the low bits of req_tdata) into a fixed-width decimal ASCII field, one character per
// rsp beat, most significant first, tlast on the final character. A negative value starts
// with '-', which uses one of the field_width characters. The magnitude is scaled by
// 10^scale_digits, rounded half up, and only the low-order digits that fit are emitted, so
// integer overflow wraps silently. A field_width of zero produces no beats. All digit work
// goes through one BCD digit register of MAX_WIDTH digits under a small sequencer: the
// integer part is shifted in one bit per cycle, then each fractional digit is appended by
// multiplying the remaining fraction by ten, then the fraction's top bit gives the rounding
// carry, which walks up one digit per cycle, then the characters leave one per cycle while
// the output is not stalled. req_tready is high only between items, while the last
// character may still sit in the output register.
module fixed_to_decimal_ascii_field #(
   parameter int MAX_WIDTH  = fxdec_pkg::DEF_MAX_WIDTH,
   parameter int FRAC_BITS  = fxdec_pkg::DEF_FRAC_BITS,
   parameter int VALUE_BITS = fxdec_pkg::DEF_VALUE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   // input stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fxdec_pkg::VALUE_W-1:0]  req_tdata,   // [63:0] value
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fxdec_pkg::CHAR_W-1:0]   rsp_tdata,   // [7:0] out_char
   output logic                           rsp_tlast,   // last_char
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fxdec_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [fxdec_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [fxdec_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                           csr_pready
);

   localparam int INT_BITS = (VALUE_BITS > FRAC_BITS) ? VALUE_BITS - FRAC_BITS : 1;
   localparam int FRAC_W   = (FRAC_BITS > 0) ? FRAC_BITS : 1;
   localparam int CW       = $clog2(MAX_WIDTH + 1);
   localparam int IW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int BW       = $clog2(INT_BITS + 1);
   localparam logic [FRAC_W-1:0] FRAC_MASK = (FRAC_BITS == 0) ? '0 : '1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DABBLE = 6'b000010,
      ST_FRAC   = 6'b000100,
      ST_ROUND  = 6'b001000,
      ST_SIGN   = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   logic [fxdec_pkg::CFG_W-1:0]     field_width_ff, field_width_in;
   logic [fxdec_pkg::CFG_W-1:0]     scale_digits_ff, scale_digits_in;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [fxdec_pkg::CHAR_W-1:0]    rsp_tdata_ff, rsp_tdata_in;
   logic                            rsp_tlast_ff, rsp_tlast_in;
   logic                            neg_ff, neg_in;
   logic                            carry_ff, carry_in;
   logic [CW-1:0]                   nchars_ff, nchars_in;
   logic [CW-1:0]                   cnt_ff, cnt_in;
   logic [BW-1:0]                   bit_cnt_ff, bit_cnt_in;
   logic [INT_BITS-1:0]             ipart_ff, ipart_in;
   logic [FRAC_W-1:0]               frac_ff, frac_in;
   logic [3:0]                      digit_ff [MAX_WIDTH];
   logic [3:0]                      digit_in [MAX_WIDTH];

   logic [VALUE_BITS-1:0]           raw;
   logic                            raw_neg;
   logic [VALUE_BITS-1:0]           mag;
   logic [6:0]                      w_clamp;
   logic [6:0]                      s_clamp;
   logic [3:0]                      dabble_adj [MAX_WIDTH];
   logic [FRAC_W+3:0]               mul10;
   logic [CW-1:0]                   cnt_dec;
   logic [3:0]                      round_digit;
   logic [3:0]                      emit_digit;
   logic                            out_free;
   logic                            csr_write;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      field_width_in  = field_width_ff;
      scale_digits_in = scale_digits_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            fxdec_pkg::REG_FIELD_WIDTH:  field_width_in  = csr_pwdata[fxdec_pkg::CFG_W-1:0];
            fxdec_pkg::REG_SCALE_DIGITS: scale_digits_in = csr_pwdata[fxdec_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         fxdec_pkg::REG_FIELD_WIDTH:
            csr_prdata = fxdec_pkg::CSR_DW'(field_width_ff);
         fxdec_pkg::REG_SCALE_DIGITS:
            csr_prdata = fxdec_pkg::CSR_DW'(scale_digits_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // Magnitude and clamped field geometry at accept time
   assign raw     = req_tdata[VALUE_BITS-1:0];
   assign raw_neg = raw[VALUE_BITS-1];
   assign mag     = raw_neg ? (~raw + 1'b1) : raw;

   always_comb begin
      w_clamp = ({1'b0, field_width_ff} > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH)
                                                         : {1'b0, field_width_ff};
      s_clamp = ({1'b0, scale_digits_ff} > w_clamp) ? w_clamp : {1'b0, scale_digits_ff};
   end

   // Shared datapath pieces: BCD doubling adjust, fraction times ten, digit reads
   always_comb begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         dabble_adj[i] = (digit_ff[i] >= fxdec_pkg::BCD_FIVE) ?
                         digit_ff[i] + fxdec_pkg::BCD_ADJ : digit_ff[i];
      end
   end

   assign mul10       = (FRAC_W+4)'({frac_ff, 3'b000}) + (FRAC_W+4)'({frac_ff, 1'b0});
   assign cnt_dec     = cnt_ff - 1'b1;
   assign round_digit = digit_ff[cnt_ff[IW-1:0]];
   assign emit_digit  = digit_ff[cnt_dec[IW-1:0]];
   assign out_free    = ~rsp_tvalid_ff | rsp_tready;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      neg_in        = neg_ff;
      carry_in      = carry_ff;
      nchars_in     = nchars_ff;
      cnt_in        = cnt_ff;
      bit_cnt_in    = bit_cnt_ff;
      ipart_in      = ipart_ff;
      frac_in       = frac_ff;
      digit_in      = digit_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      case (state_ff)
         ST_IDLE: begin
            // take a value; an empty field produces nothing
            if (req_tvalid && w_clamp != 7'd0) begin
               neg_in     = raw_neg;
               nchars_in  = CW'(w_clamp) - CW'(raw_neg);
               cnt_in     = CW'(s_clamp);
               bit_cnt_in = BW'(INT_BITS);
               ipart_in   = INT_BITS'(mag >> FRAC_BITS);
               frac_in    = FRAC_W'(mag) & FRAC_MASK;
               for (int i = 0; i < MAX_WIDTH; i++) begin
                  digit_in[i] = 4'd0;
               end
               state_in   = ST_DABBLE;
            end
         end

         ST_DABBLE: begin
            // shift one integer bit into the BCD digits, top digit carry dropped
            for (int i = 0; i < MAX_WIDTH; i++) begin
               if (i == 0) begin
                  digit_in[i] = {dabble_adj[i][2:0], ipart_ff[INT_BITS-1]};
               end else begin
                  digit_in[i] = {dabble_adj[i][2:0], dabble_adj[i-1][3]};
               end
            end
            ipart_in   = ipart_ff << 1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == BW'(1)) begin
               state_in = ST_FRAC;
            end
         end

         ST_FRAC: begin
            // append one fractional digit per cycle
            if (cnt_ff != '0) begin
               for (int i = 0; i < MAX_WIDTH; i++) begin
                  if (i == 0) begin
                     digit_in[i] = mul10[FRAC_W+3:FRAC_W];
                  end else begin
                     digit_in[i] = digit_ff[i-1];
                  end
               end
               frac_in = mul10[FRAC_W-1:0];
               cnt_in  = cnt_dec;
            end else begin
               carry_in = frac_ff[FRAC_W-1];
               cnt_in   = '0;
               state_in = ST_ROUND;
            end
         end

         ST_ROUND: begin
            // walk the rounding carry up through trailing nines
            if (!carry_ff || cnt_ff == CW'(MAX_WIDTH)) begin
               cnt_in   = nchars_ff;
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end else if (round_digit == fxdec_pkg::BCD_NINE) begin
               digit_in[cnt_ff[IW-1:0]] = 4'd0;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               digit_in[cnt_ff[IW-1:0]] = round_digit + 4'd1;
               carry_in = 1'b0;
            end
         end

         ST_SIGN: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = fxdec_pkg::CHAR_MINUS;
               rsp_tlast_in  = (nchars_ff == '0);
               cnt_in        = nchars_ff;
               state_in      = (nchars_ff == '0) ? ST_IDLE : ST_EMIT;
            end
         end

         ST_EMIT: begin
            // emit digits most significant first
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = fxdec_pkg::CHAR_ZERO + {4'd0, emit_digit};
               rsp_tlast_in  = (cnt_ff == CW'(1));
               cnt_in        = cnt_dec;
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_tvalid_ff   <= 1'b0;
         field_width_ff  <= fxdec_pkg::FIELD_WIDTH_RST;
         scale_digits_ff <= fxdec_pkg::SCALE_DIGITS_RST;
      end else begin
         state_ff        <= state_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
         field_width_ff  <= field_width_in;
         scale_digits_ff <= scale_digits_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      carry_ff     <= carry_in;
      nchars_ff    <= nchars_in;
      cnt_ff       <= cnt_in;
      bit_cnt_ff   <= bit_cnt_in;
      ipart_ff     <= ipart_in;
      frac_ff      <= frac_in;
      digit_ff     <= digit_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

// ===== sv/fxdec_checker.sv =====
module fxdec_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [fxdec_pkg::CHAR_W-1:0] rsp_tdata,
   input logic                         rsp_tlast
);

   // Output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // A stalled beat holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result beat changed");

   // Every character is a minus sign or a decimal digit
   a_charset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == fxdec_pkg::CHAR_MINUS ||
                      (rsp_tdata >= fxdec_pkg::CHAR_ZERO && rsp_tdata <= fxdec_pkg::CHAR_NINE)))
      else $error("result character out of range");

   // Mid-field the block cannot take a new value
   a_busy_midfield: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> !req_tready)
      else $error("input ready while a field is still being sent");

   // A minus sign that is not the final character is not followed by another minus sign
   a_minus_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tdata == fxdec_pkg::CHAR_MINUS && !rsp_tlast) |=>
      !(rsp_tvalid && rsp_tdata == fxdec_pkg::CHAR_MINUS))
      else $error("minus sign repeated within a field");

endmodule

bind fixed_to_decimal_ascii_field fxdec_checker u_fxdec_checker (.*);
